FILE: rtl/core/lsg_pkg.sv
// Shared constants and codes of the line span generator.
`default_nettype none

package lsg_pkg;

	localparam int COORD_W = 16;
	localparam int SPAN_W = 17;
	localparam int COLOR_W = 8;
	localparam int COORD_BITS_DEF = 16;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/lsg_cmd_if.sv
// Command channel of the line span generator: start and next-span requests.
`default_nettype none

interface lsg_cmd_if;
	import lsg_pkg::*;

	logic valid;
	logic ready;
	logic action;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic [COLOR_W-1:0] red_in;
	logic [COLOR_W-1:0] green_in;
	logic [COLOR_W-1:0] blue_in;

	modport source (
		output valid, action, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
		input ready
	);

	modport sink (
		input valid, action, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
		output ready
	);

endinterface

`default_nettype wire

FILE: rtl/core/lsg_span_if.sv
// Span channel of the line span generator: at most one rectangle per transaction.
`default_nettype none

interface lsg_span_if;
	import lsg_pkg::*;

	logic valid;
	logic ready;
	logic span_valid;
	logic signed [COORD_W-1:0] span_x;
	logic signed [COORD_W-1:0] span_y;
	logic [SPAN_W-1:0] span_width;
	logic [SPAN_W-1:0] span_height;
	logic [COLOR_W-1:0] red_out;
	logic [COLOR_W-1:0] green_out;
	logic [COLOR_W-1:0] blue_out;
	logic last_span;

	modport source (
		output valid, span_valid, span_x, span_y, span_width, span_height,
		output red_out, green_out, blue_out, last_span,
		input ready
	);

	modport sink (
		input valid, span_valid, span_x, span_y, span_width, span_height,
		input red_out, green_out, blue_out, last_span,
		output ready
	);

endinterface

`default_nettype wire

FILE: rtl/core/line_span_generator.sv
// A start transaction runs through PREP, SETUP, LOAD, DIV and EMIT before its first span.
// A next transaction runs through LOAD, DIV and EMIT, where DIV is the restoring divider
// that yields one quotient bit per cycle over COORD_BITS+2 bits; a next while idle goes to EMIT.
// One transaction is worked on at a time: commands are taken only in IDLE, so starts, nexts and
// idle nexts wait until the last one has left EMIT; a span waits in the output register.
// Reset is asynchronous: it clears the state machine, the active line and the output valid.
`default_nettype none

module line_span_generator #(
	parameter int COORD_BITS = lsg_pkg::COORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	lsg_cmd_if.sink        cmd,
	lsg_span_if.source     span
);
	import lsg_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int LW = CW + 1;
	localparam int DW = CW + 2;
	localparam int CNT_W = $clog2(DW);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PREP  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_LOAD  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;
	logic active_q;
	logic zero_q;

	logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [COLOR_W-1:0] red_q, green_q, blue_q;

	logic [LW-1:0] dx_q, dy_q;
	logic xlt_q, ylt_q;

	logic signed [CW-1:0] cur_x_q, cur_y_q;
	logic [LW-1:0] len_q, steps_q, left_q, r_q;
	logic x_major_q, minor_neg_q;

	logic [DW-1:0] dvd_q;
	logic [LW-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	logic out_valid_q;
	logic o_span_valid_q, o_last_q;
	logic signed [COORD_W-1:0] o_x_q, o_y_q;
	logic [SPAN_W-1:0] o_w_q, o_h_q;
	logic [COLOR_W-1:0] o_red_q, o_green_q, o_blue_q;

	logic cmd_fire;
	logic out_free;
	logic xlt, ylt, x_major;
	logic signed [LW-1:0] x1e, x2e, y1e, y2e;
	logic [LW-1:0] dx, dy;
	logic [DW-1:0] shifted;
	logic [DW:0] trial;
	logic borrow;
	logic [LW-1:0] run;
	logic last;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || span.ready;

	assign x1e = LW'(x1_q);
	assign x2e = LW'(x2_q);
	assign y1e = LW'(y1_q);
	assign y2e = LW'(y2_q);
	assign xlt = x1_q < x2_q;
	assign ylt = y1_q < y2_q;
	assign dx = (xlt ? x2e - x1e : x1e - x2e) + LW'(1);
	assign dy = (ylt ? y2e - y1e : y1e - y2e) + LW'(1);
	assign x_major = dx_q > dy_q;

	assign shifted = {rem_q, dvd_q[DW-1]};
	assign trial = {1'b0, shifted} - (DW + 1)'(steps_q);
	assign borrow = trial[DW];
	assign run = dvd_q[LW-1:0];
	assign last = (left_q == LW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			zero_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (span.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd.action == ACT_START) begin
							zero_q <= 1'b0;
							state_q <= ST_PREP;
						end else if (active_q) begin
							zero_q <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							zero_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_PREP: begin
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					active_q <= 1'b1;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DW - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!zero_q && last) begin
							active_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && cmd.action == ACT_START) begin
					x1_q <= cmd.start_x[CW-1:0];
					y1_q <= cmd.start_y[CW-1:0];
					x2_q <= cmd.end_x[CW-1:0];
					y2_q <= cmd.end_y[CW-1:0];
					red_q <= cmd.red_in;
					green_q <= cmd.green_in;
					blue_q <= cmd.blue_in;
				end
			end
			ST_PREP: begin
				dx_q <= dx;
				dy_q <= dy;
				xlt_q <= xlt;
				ylt_q <= ylt;
			end
			ST_SETUP: begin
				x_major_q <= x_major;
				len_q <= x_major ? dx_q : dy_q;
				steps_q <= x_major ? dy_q : dx_q;
				left_q <= x_major ? dy_q : dx_q;
				r_q <= '0;
				if (x_major) begin
					cur_x_q <= xlt_q ? x1_q : x2_q;
					cur_y_q <= xlt_q ? y1_q : y2_q;
					minor_neg_q <= xlt_q ? !ylt_q : ylt_q;
				end else begin
					cur_x_q <= ylt_q ? x1_q : x2_q;
					cur_y_q <= ylt_q ? y1_q : y2_q;
					minor_neg_q <= ylt_q ? !xlt_q : xlt_q;
				end
			end
			ST_LOAD: begin
				dvd_q <= DW'(r_q) + DW'(len_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= borrow ? shifted[LW-1:0] : trial[LW-1:0];
				dvd_q <= {dvd_q[DW-2:0], !borrow};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_EMIT: begin
				if (out_free) begin
					if (zero_q) begin
						o_span_valid_q <= 1'b0;
						o_x_q <= '0;
						o_y_q <= '0;
						o_w_q <= '0;
						o_h_q <= '0;
						o_red_q <= '0;
						o_green_q <= '0;
						o_blue_q <= '0;
						o_last_q <= 1'b0;
					end else begin
						o_span_valid_q <= 1'b1;
						o_x_q <= COORD_W'(cur_x_q);
						o_y_q <= COORD_W'(cur_y_q);
						o_w_q <= x_major_q ? SPAN_W'(run) : SPAN_W'(1);
						o_h_q <= x_major_q ? SPAN_W'(1) : SPAN_W'(run);
						o_red_q <= red_q;
						o_green_q <= green_q;
						o_blue_q <= blue_q;
						o_last_q <= last;
						r_q <= rem_q;
						left_q <= left_q - LW'(1);
						if (x_major_q) begin
							cur_x_q <= cur_x_q + CW'(run);
							cur_y_q <= minor_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
						end else begin
							cur_y_q <= cur_y_q + CW'(run);
							cur_x_q <= minor_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign span.valid = out_valid_q;
	assign span.span_valid = o_span_valid_q;
	assign span.span_x = o_x_q;
	assign span.span_y = o_y_q;
	assign span.span_width = o_w_q;
	assign span.span_height = o_h_q;
	assign span.red_out = o_red_q;
	assign span.green_out = o_green_q;
	assign span.blue_out = o_blue_q;
	assign span.last_span = o_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/lsg_checker.sv
// Port-level checks of the line span generator and their binding to it.
`default_nettype none

module lsg_checker (
	input  logic       clk,
	input  logic       arst_n,
	lsg_cmd_if.sink    cmd,
	lsg_span_if.source span
);
	import lsg_pkg::*;

	// A pending span transaction stays offered until it is taken.
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span.valid && !span.ready |=> span.valid)
		else $error("span transaction withdrawn before it was taken");

	// The block works on one command transaction at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted while the previous one is still in work");

	// A result without a span carries nothing else.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		span.valid && !span.span_valid |->
			span.span_x == '0 && span.span_y == '0 && span.span_width == '0 &&
			span.span_height == '0 && span.red_out == '0 && span.green_out == '0 &&
			span.blue_out == '0 && !span.last_span)
		else $error("empty result carries nonzero fields");

	// A span is one pixel thick on its minor axis and never empty.
	a_span_shape: assert property (@(posedge clk) disable iff (!arst_n)
		span.valid && span.span_valid |->
			(span.span_width == SPAN_W'(1) || span.span_height == SPAN_W'(1)) &&
			span.span_width != '0 && span.span_height != '0)
		else $error("span has a malformed shape");

endmodule

bind line_span_generator lsg_checker u_lsg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.span   (span)
);

`default_nettype wire
